FILE: rtl/sps_pkg.sv
// Shared types and constants for the slotted page store.
// Used by the channel interfaces and by slotted_page_store_unit; no dependencies.
package sps_pkg;

   // Default geometry of the page
   localparam int PAGE_BYTES_DEF = 4096;
   localparam int MAX_SLOTS_DEF  = 1024;

   // Directory cost charged against free space
   localparam int HEADER_COST = 12;
   localparam int SLOT_COST   = 4;

   // Field widths of the channels
   localparam int CMD_W       = 3;
   localparam int SLOT_W      = 10;
   localparam int INDEX_W     = 12;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 12;
   localparam int STATUS_W    = 3;
   localparam int OFFSET_W    = 13;
   localparam int SIZE_W      = 13;
   localparam int PAGE_ID_W   = 31;
   localparam int COUNT_OUT_W = 11;
   localparam int INS_CNT_W   = 13;

   // Request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_LOOKUP = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_READ   = 3'd3,
      CMD_INIT   = 3'd4
   } cmd_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NO_ROOM  = 3'd1,
      ST_NO_SLOT  = 3'd2,
      ST_GONE     = 3'd3,
      ST_LEN_MISS = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SLOT_RD,
      S_BYTE_RD,
      S_DONE
   } state_type;

   // One response item
   typedef struct packed {
      status_type             status;
      logic [SLOT_W-1:0]      slot_no;
      logic [OFFSET_W-1:0]    tuple_offset;
      logic [SIZE_W-1:0]      tuple_size;
      logic [PAGE_ID_W-1:0]   rid_page;
      logic [BYTE_W-1:0]      data_out;
      logic [COUNT_OUT_W-1:0] slot_count;
   } rsp_type;

endpackage

FILE: rtl/sps_req_if.sv
// Request channel of the slotted page store: valid/ready plus command payload.
// Depends on sps_pkg for field widths.
interface sps_req_if import sps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [SLOT_W-1:0]    slot;
   logic [INDEX_W-1:0]   byte_index;
   logic [BYTE_W-1:0]    data_byte;
   logic [LEN_W-1:0]     tuple_len;
   logic                 last;

   modport source (output valid, cmd, slot, byte_index, data_byte, tuple_len, last,
                   input ready);
   modport sink   (input valid, cmd, slot, byte_index, data_byte, tuple_len, last,
                   output ready);
endinterface

FILE: rtl/sps_rsp_if.sv
// Response channel of the slotted page store: valid/ready plus result payload.
// Depends on sps_pkg for field widths.
interface sps_rsp_if import sps_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [SLOT_W-1:0]      slot_no;
   logic [OFFSET_W-1:0]    tuple_offset;
   logic [SIZE_W-1:0]      tuple_size;
   logic [PAGE_ID_W-1:0]   rid_page;
   logic [BYTE_W-1:0]      data_out;
   logic [COUNT_OUT_W-1:0] slot_count;

   modport source (output valid, status, slot_no, tuple_offset, tuple_size, rid_page,
                   data_out, slot_count, input ready);
   modport sink   (input valid, status, slot_no, tuple_offset, tuple_size, rid_page,
                   data_out, slot_count, output ready);
endinterface

FILE: rtl/slotted_page_store_unit.sv
// Slotted page store: byte store and slot directory in two synchronous memories.
// Depends on sps_pkg, sps_req_if and sps_rsp_if.
//
// Usage:
//   req_chan carries one command per transfer: insert byte, lookup, delete,
//   read tuple byte or init. Tuples are inserted one byte per transfer with the
//   length on the first byte and last on the final byte. rsp_chan returns at
//   most one result per command; insert bytes that are not last return none,
//   and unknown command codes are taken and dropped.
//   csr_write_enable/csr_write_data set the page id returned in rid_page.
// Sequencing (states from one request transfer to the next accept):
//   insert byte, not last: stays idle (one byte per cycle, written straight to the
//   byte memory); final insert byte, init, slot out of range: done;
//   lookup, delete, failed read: slot read, then done (one slot memory read);
//   read tuple byte: slot read (slot memory), byte read (byte memory), done.
//   The result moves into the output register from the done state.
// Reset clears the counters, free pointer and insert state; the memories are
// not cleared and need no clearing pass. When rsp_chan stalls, the finished
// result waits in the output register and the next command is still taken;
// a later result waits in the sequencer until the register frees up.
module slotted_page_store_unit import sps_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF,
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [PAGE_ID_W-1:0] csr_write_data,
   sps_req_if.sink              req_chan,
   sps_rsp_if.source            rsp_chan
);

   // Derived widths
   localparam int AW  = $clog2(PAGE_BYTES);          // byte memory address
   localparam int PW  = $clog2(PAGE_BYTES + 1);      // offsets and free pointer
   localparam int SW  = $clog2(MAX_SLOTS);           // slot memory address
   localparam int CW  = $clog2(MAX_SLOTS + 1);       // slot count
   localparam int EW  = (CW > SLOT_W) ? CW : SLOT_W; // slot range compare
   localparam int NW  = $clog2(HEADER_COST + SLOT_COST * (MAX_SLOTS + 1)
                               + (1 << LEN_W) + PAGE_BYTES + 1);
   localparam int DW  = PW + LEN_W;                  // slot entry: offset, size

   // Memories
   logic [BYTE_W-1:0] page_mem [PAGE_BYTES];
   logic [DW-1:0]     slot_mem [MAX_SLOTS];

   // Control registers
   state_type             state_ff, state_in;
   logic [PAGE_ID_W-1:0]  page_id_ff;
   logic [CW-1:0]         used_ff, used_in;
   logic [PW-1:0]         fp_ff, fp_in;
   logic                  ins_act_ff, ins_act_in;
   logic                  ins_rej_ff, ins_rej_in;
   logic [PW-1:0]         ins_base_ff, ins_base_in;
   logic [LEN_W-1:0]      ins_len_ff, ins_len_in;
   logic [INS_CNT_W-1:0]  ins_cnt_ff, ins_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [CMD_W-1:0]      cmd_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [INDEX_W-1:0]    idx_ff;
   rsp_type               res_ff, res_in;
   rsp_type               out_ff;
   logic [DW-1:0]         slot_rd_ff;
   logic [BYTE_W-1:0]     page_rd_ff;

   // Datapath signals
   logic                  accept;
   logic                  out_load;
   logic                  start;
   logic [NW-1:0]         need;
   logic                  admit;
   logic                  cur_rej;
   logic [LEN_W-1:0]      cur_len;
   logic [PW-1:0]         cur_base;
   logic [INS_CNT_W-1:0]  cur_cnt;
   logic                  carries;
   logic                  store;
   logic [INS_CNT_W-1:0]  cnt_next;
   logic                  mismatch;
   logic                  slot_oor;
   logic [PW-1:0]         entry_off;
   logic [LEN_W-1:0]      entry_size;
   logic                  read_bad;
   logic                  page_we;
   logic [AW-1:0]         page_waddr;
   logic [AW-1:0]         page_raddr;
   logic                  slot_we;
   logic [SW-1:0]         slot_waddr;
   logic [DW-1:0]         slot_wdata;

   // Handshake
   assign accept   = req_chan.valid && (state_ff == S_IDLE);
   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == S_IDLE);

   // Insert bookkeeping for the current byte
   assign start    = !ins_act_ff;
   assign need     = NW'(HEADER_COST + SLOT_COST) + NW'(SLOT_COST) * NW'(used_ff)
                     + NW'(req_chan.tuple_len);
   assign admit    = (used_ff < CW'(MAX_SLOTS)) && (NW'(fp_ff) >= need);
   assign cur_rej  = start ? !admit : ins_rej_ff;
   assign cur_len  = start ? req_chan.tuple_len : ins_len_ff;
   assign cur_base = start ? (admit ? fp_ff - PW'(req_chan.tuple_len) : '0) : ins_base_ff;
   assign cur_cnt  = start ? '0 : ins_cnt_ff;
   assign carries  = !(start && (req_chan.tuple_len == '0));
   assign store    = carries && !cur_rej && (cur_cnt < INS_CNT_W'(cur_len));
   assign cnt_next = (carries && (cur_cnt != '1)) ? cur_cnt + 1'b1 : cur_cnt;
   assign mismatch = (cnt_next != INS_CNT_W'(cur_len));

   // Slot checks and entry fields
   assign slot_oor   = (EW'(req_chan.slot) >= EW'(used_ff));
   assign entry_off  = slot_rd_ff[LEN_W +: PW];
   assign entry_size = slot_rd_ff[LEN_W-1:0];
   assign read_bad   = (entry_size == '0) || (idx_ff >= entry_size);
   assign page_waddr = AW'(cur_base + PW'(cur_cnt));
   assign page_raddr = AW'(entry_off + PW'(idx_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_INSERT: begin
                     if (req_chan.last) state_in = S_DONE;
                  end
                  CMD_INIT: state_in = S_DONE;
                  CMD_LOOKUP, CMD_DELETE, CMD_READ: begin
                     state_in = slot_oor ? S_DONE : S_SLOT_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SLOT_RD: begin
            state_in = (cmd_ff == CMD_READ && !read_bad) ? S_BYTE_RD : S_DONE;
         end
         S_BYTE_RD: state_in = S_DONE;
         S_DONE: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      used_in     = used_ff;
      fp_in       = fp_ff;
      ins_act_in  = ins_act_ff;
      ins_rej_in  = ins_rej_ff;
      ins_base_in = ins_base_ff;
      ins_len_in  = ins_len_ff;
      ins_cnt_in  = ins_cnt_ff;
      res_in      = res_ff;
      page_we     = 1'b0;
      slot_we     = 1'b0;
      slot_waddr  = SW'(slot_ff);
      slot_wdata  = {entry_off, {LEN_W{1'b0}}};

      // Common result fields
      if (state_ff != S_DONE) begin
         res_in.rid_page   = page_id_ff;
         res_in.data_out   = '0;
         res_in.slot_count = COUNT_OUT_W'(used_ff);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_INSERT: begin
                     // advance the insert and store the byte
                     page_we     = store;
                     ins_act_in  = !req_chan.last;
                     ins_rej_in  = req_chan.last ? 1'b0 : cur_rej;
                     ins_base_in = cur_base;
                     ins_len_in  = cur_len;
                     ins_cnt_in  = cnt_next;
                     res_in.slot_no      = '0;
                     res_in.tuple_offset = '0;
                     res_in.tuple_size   = '0;
                     if (cur_rej) begin
                        res_in.status = ST_NO_ROOM;
                     end else if (mismatch) begin
                        res_in.status = ST_LEN_MISS;
                     end else begin
                        res_in.status       = ST_OK;
                        res_in.slot_no      = SLOT_W'(used_ff);
                        res_in.tuple_offset = OFFSET_W'(cur_base);
                        res_in.tuple_size   = SIZE_W'(cur_len);
                        res_in.slot_count   = COUNT_OUT_W'(used_ff + 1'b1);
                        if (req_chan.last) begin
                           slot_we    = 1'b1;
                           slot_waddr = SW'(used_ff);
                           slot_wdata = {cur_base, cur_len};
                           fp_in      = cur_base;
                           used_in    = used_ff + 1'b1;
                        end
                     end
                  end
                  CMD_INIT: begin
                     // empty the page, drop any pending insert
                     ins_act_in = 1'b0;
                     ins_rej_in = 1'b0;
                     used_in    = '0;
                     fp_in      = PW'(PAGE_BYTES);
                     res_in.status       = ST_OK;
                     res_in.slot_no      = '0;
                     res_in.tuple_offset = '0;
                     res_in.tuple_size   = '0;
                     res_in.slot_count   = '0;
                  end
                  CMD_LOOKUP, CMD_DELETE, CMD_READ: begin
                     ins_act_in = 1'b0;
                     ins_rej_in = 1'b0;
                     res_in.status       = ST_NO_SLOT;
                     res_in.slot_no      = req_chan.slot;
                     res_in.tuple_offset = '0;
                     res_in.tuple_size   = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SLOT_RD: begin
            res_in.slot_no      = slot_ff;
            res_in.status       = ST_OK;
            res_in.tuple_offset = OFFSET_W'(entry_off);
            res_in.tuple_size   = SIZE_W'(entry_size);
            case (cmd_ff)
               CMD_LOOKUP: begin
                  if (entry_size == '0) res_in.status = ST_GONE;
               end
               CMD_DELETE: begin
                  // write back the entry with its size cleared
                  slot_we = 1'b1;
                  res_in.tuple_size = '0;
               end
               default: begin
                  if (read_bad) begin
                     res_in.status       = ST_GONE;
                     res_in.tuple_offset = '0;
                     res_in.tuple_size   = '0;
                  end
               end
            endcase
         end
         S_BYTE_RD: res_in.data_out = page_rd_ff;
         S_DONE: ;
         default: ;
      endcase
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         page_id_ff   <= '0;
         used_ff      <= '0;
         fp_ff        <= PW'(PAGE_BYTES);
         ins_act_ff   <= 1'b0;
         ins_rej_ff   <= 1'b0;
         ins_base_ff  <= '0;
         ins_len_ff   <= '0;
         ins_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) page_id_ff <= csr_write_data;
         used_ff      <= used_in;
         fp_ff        <= fp_in;
         ins_act_ff   <= ins_act_in;
         ins_rej_ff   <= ins_rej_in;
         ins_base_ff  <= ins_base_in;
         ins_len_ff   <= ins_len_in;
         ins_cnt_ff   <= ins_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold the command, the pending result and the output
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_chan.cmd;
         slot_ff <= req_chan.slot;
         idx_ff  <= req_chan.byte_index;
      end
      res_ff <= res_in;
      if (out_load) out_ff <= res_ff;
   end

   // Byte memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (page_we) page_mem[page_waddr] <= req_chan.data_byte;
      page_rd_ff <= page_mem[page_raddr];
   end

   // Slot memory: one write, one registered read; the sequencer never reads
   // an entry in the cycle it is written, so no forwarding path is needed
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      slot_rd_ff <= slot_mem[SW'(req_chan.slot)];
   end

   // Response port
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.slot_no      = out_ff.slot_no;
   assign rsp_chan.tuple_offset = out_ff.tuple_offset;
   assign rsp_chan.tuple_size   = out_ff.tuple_size;
   assign rsp_chan.rid_page     = out_ff.rid_page;
   assign rsp_chan.data_out     = out_ff.data_out;
   assign rsp_chan.slot_count   = out_ff.slot_count;

   // Free space never runs below the directory
   a_fp_covers_dir: assert property (@(posedge clock) disable iff (reset)
      NW'(fp_ff) >= NW'(HEADER_COST) + NW'(SLOT_COST) * NW'(used_ff))
      else $error("free pointer below directory end");

   // Slot count stays within the directory
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_SLOTS))
      else $error("slot count beyond directory size");

   // A rejected insert is always a pending one
   a_rej_active: assert property (@(posedge clock) disable iff (reset)
      ins_rej_ff |-> ins_act_ff)
      else $error("rejected flag without pending insert");

   // A slot read finishes or moves on to the byte read
   a_slot_rd_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SLOT_RD |=> state_ff == S_DONE || state_ff == S_BYTE_RD)
      else $error("slot read step did not advance");

   // The output register fills only from the finished result
   a_out_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised without a finished result");

endmodule
